### design/bitmap_copy_realigner_defines.svh
// assertion macros for the bitmap copy realigner
// no dependencies; assertions sample on clk, the implication check uses rst as the reset
`ifndef BITMAP_COPY_REALIGNER_DEFINES_SVH
`define BITMAP_COPY_REALIGNER_DEFINES_SVH

`ifndef SYNTHESIS
// implication checked on every edge outside reset
`define BCR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication into the next cycle, also checked across reset
`define BCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`else
`define BCR_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define BCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/bcr_pkg.sv
// shared types, constants and helper functions of the bitmap copy realigner
// no dependencies
package bcr_pkg;

  localparam int WORD_BITS   = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int INDEX_WIDTH = 26;
  localparam int POS_WIDTH   = $clog2(WORD_BITS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;

  // one queue entry: the words a single source byte completes
  typedef struct packed {
    logic [WORD_BITS-1:0]   word_a;
    logic [WORD_BITS-1:0]   mask_a;
    logic [INDEX_WIDTH-1:0] index_a;
    logic                   last_a;
    logic                   has_b;
    logic [WORD_BITS-1:0]   word_b;
    logic [WORD_BITS-1:0]   mask_b;
  } entry_t;

  // low n bits set, all ones for n >= WORD_BITS
  function automatic logic [WORD_BITS-1:0] ones_below(input logic [POS_WIDTH:0] n);
    logic [WORD_BITS-1:0] r;
    if (n[POS_WIDTH]) begin
      r = '1;
    end else begin
      r = (WORD_BITS'(1) << n[POS_WIDTH-1:0]) - WORD_BITS'(1);
    end
    return r;
  endfunction

endpackage

### design/bcr_front.sv
// front end: accepts start and byte transactions, keeps the job state and packs bits
// depends on bcr_pkg
module bcr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take_in,
  input  logic                          mode,
  input  logic [7:0]                    source_byte,
  input  logic [2:0]                    source_bit_offset,
  input  logic [31:0]                   target_bit_offset,
  input  logic [31:0]                   bit_count,
  output logic                          entry_push,
  output bcr_pkg::entry_t               entry
);
  import bcr_pkg::*;

  logic [WORD_BITS-1:0]   packed_word;
  logic [POS_WIDTH-1:0]   fill_position;
  logic [POS_WIDTH-1:0]   word_start_position;
  logic [COUNT_WIDTH-1:0] bits_remaining;
  logic [INDEX_WIDTH-1:0] current_word_index;
  logic [2:0]             first_skip;
  logic                   first_byte_pending;

  logic [2:0]             skip;
  logic [3:0]             take_full;
  logic [3:0]             take;
  logic [WORD_BITS-1:0]   take_mask;
  logic [7:0]             bits;
  logic [COUNT_WIDTH-1:0] rem_next;
  logic [WORD_BITS+7:0]   wide;
  logic [WORD_BITS-1:0]   merged;
  logic [POS_WIDTH:0]     end_pos;
  logic [WORD_BITS-1:0]   head_mask;
  logic                   active;
  logic                   word_full;

  always_comb begin
    skip      = first_byte_pending ? first_skip : 3'd0;
    take_full = 4'd8 - {1'b0, skip};
    if (bits_remaining < COUNT_WIDTH'(take_full)) begin
      take = bits_remaining[3:0];
    end else begin
      take = take_full;
    end
    take_mask = ones_below((POS_WIDTH+1)'(take));
    bits      = (source_byte >> skip) & take_mask[7:0];
    rem_next  = bits_remaining - COUNT_WIDTH'(take);
    wide      = (WORD_BITS+8)'(bits) << fill_position;
    merged    = packed_word | wide[WORD_BITS-1:0];
    end_pos   = {1'b0, fill_position} + (POS_WIDTH+1)'(take);
    head_mask = ~ones_below({1'b0, word_start_position});
    active    = bits_remaining != '0;
    word_full = end_pos[POS_WIDTH];
  end

  always_comb begin
    entry         = '0;
    entry.index_a = current_word_index;
    if (word_full) begin
      entry.mask_a = head_mask;
      entry.word_a = merged & head_mask;
      entry.last_a = (rem_next == '0) && (end_pos[POS_WIDTH-1:0] == '0);
      entry.has_b  = (rem_next == '0) && (end_pos[POS_WIDTH-1:0] != '0);
      entry.mask_b = ones_below({1'b0, end_pos[POS_WIDTH-1:0]});
      entry.word_b = WORD_BITS'(wide[WORD_BITS+7:WORD_BITS]) & entry.mask_b;
    end else begin
      entry.mask_a = ones_below(end_pos) & head_mask;
      entry.word_a = merged & entry.mask_a;
      entry.last_a = 1'b1;
    end
  end

  assign entry_push = take_in && (mode == MODE_BYTE) && active
                      && (word_full || (rem_next == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      packed_word         <= '0;
      fill_position       <= '0;
      word_start_position <= '0;
      bits_remaining      <= '0;
      current_word_index  <= '0;
      first_skip          <= '0;
      first_byte_pending  <= 1'b0;
    end else if (take_in) begin
      if (mode == MODE_START) begin
        bits_remaining      <= bit_count[COUNT_WIDTH-1:0];
        word_start_position <= target_bit_offset[POS_WIDTH-1:0];
        fill_position       <= target_bit_offset[POS_WIDTH-1:0];
        current_word_index  <= target_bit_offset[POS_WIDTH+INDEX_WIDTH-1:POS_WIDTH];
        first_skip          <= source_bit_offset;
        first_byte_pending  <= 1'b1;
        packed_word         <= '0;
      end else if (active) begin
        first_byte_pending <= 1'b0;
        bits_remaining     <= rem_next;
        if (word_full) begin
          packed_word         <= WORD_BITS'(wide[WORD_BITS+7:WORD_BITS]);
          current_word_index  <= current_word_index + INDEX_WIDTH'(1);
          word_start_position <= '0;
          fill_position       <= end_pos[POS_WIDTH-1:0];
        end else begin
          packed_word   <= merged;
          fill_position <= end_pos[POS_WIDTH-1:0];
        end
      end
    end
  end

endmodule

### design/bcr_queue.sv
// short entry queue between the front end and the output stage
// depends on bcr_pkg
module bcr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  bcr_pkg::entry_t wr_entry,
  input  logic            rd_en,
  output bcr_pkg::entry_t rd_entry,
  output logic            q_full,
  output logic            q_nonempty
);
  import bcr_pkg::*;

  entry_t                slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QPTR_WIDTH:0]   count;

  assign q_full     = count == (QPTR_WIDTH+1)'(QUEUE_DEPTH);
  assign q_nonempty = count != '0;
  assign rd_entry   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_WIDTH'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_WIDTH'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (QPTR_WIDTH+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (QPTR_WIDTH+1)'(1);
      end
    end
  end

endmodule

### design/bcr_back.sv
// back end: holds one entry and hands out its one or two result words
// depends on bcr_pkg
module bcr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bcr_pkg::entry_t               q_entry,
  input  logic                          q_nonempty,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [bcr_pkg::WORD_BITS-1:0] target_word,
  output logic [bcr_pkg::WORD_BITS-1:0] write_mask,
  output logic [bcr_pkg::INDEX_WIDTH-1:0] word_index,
  output logic                          last
);
  import bcr_pkg::*;

  entry_t cur;
  logic   cur_valid;
  logic   sel_b;
  logic   taken;
  logic   advance;

  assign taken   = pop && cur_valid;
  assign advance = !cur_valid || (taken && (sel_b || !cur.has_b));
  assign q_pop   = advance && q_nonempty;

  assign empty       = !cur_valid;
  assign target_word = sel_b ? cur.word_b : cur.word_a;
  assign write_mask  = sel_b ? cur.mask_b : cur.mask_a;
  assign word_index  = sel_b ? cur.index_a + INDEX_WIDTH'(1) : cur.index_a;
  assign last        = sel_b ? 1'b1 : cur.last_a;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel_b     <= 1'b0;
    end else if (advance) begin
      cur_valid <= q_nonempty;
      sel_b     <= 1'b0;
    end else if (taken) begin
      sel_b <= 1'b1;
    end
  end

endmodule

### design/bitmap_copy_realigner.sv
// bitmap copy realigner: an accepted source byte's first word is registered in the queue, then in the output stage
// one transaction per cycle unless full; a byte that closes two words holds the output for both
// the 4-entry queue between packer and output stage absorbs such bursts and output stalls
// reset: synchronous, active high; clears the job (none active), the queue and the output
// depends on bcr_pkg, bcr_front, bcr_queue, bcr_back and the assertion macro header
module bitmap_copy_realigner (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            mode,
  input  logic [7:0]                      source_byte,
  input  logic [2:0]                      source_bit_offset,
  input  logic [31:0]                     target_bit_offset,
  input  logic [31:0]                     bit_count,
  output logic                            empty,
  input  logic                            pop,
  output logic [bcr_pkg::WORD_BITS-1:0]   target_word,
  output logic [bcr_pkg::WORD_BITS-1:0]   write_mask,
  output logic [bcr_pkg::INDEX_WIDTH-1:0] word_index,
  output logic                            last
);
  import bcr_pkg::*;
`include "bitmap_copy_realigner_defines.svh"

  // input transaction taken this cycle
  logic   take_in;
  // front end to queue
  logic   entry_push;
  entry_t entry;
  // queue to output stage
  entry_t q_entry;
  logic   q_pop;
  logic   q_full;
  logic   q_nonempty;

  // the packer never stalls on its own; only a full queue holds off the source
  assign full    = q_full;
  assign take_in = push && !q_full;

  // packer: job state, skip of leading bits, shift and merge into the word
  bcr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .take_in           (take_in),
    .mode              (mode),
    .source_byte       (source_byte),
    .source_bit_offset (source_bit_offset),
    .target_bit_offset (target_bit_offset),
    .bit_count         (bit_count),
    .entry_push        (entry_push),
    .entry             (entry)
  );

  // decoupling queue, one entry per byte that finishes a word or the job
  bcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (entry_push),
    .wr_entry   (entry),
    .rd_en      (q_pop),
    .rd_entry   (q_entry),
    .q_full     (q_full),
    .q_nonempty (q_nonempty)
  );

  // output stage: presents the entry's first word, then the trailing partial word if any
  bcr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_entry     (q_entry),
    .q_nonempty  (q_nonempty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .target_word (target_word),
    .write_mask  (write_mask),
    .word_index  (word_index),
    .last        (last)
  );

  // every shown word writes at least one bit
  `BCR_ASSERT_IMPLIES(a_mask_nonzero, !empty, write_mask != '0, "empty write mask on output")
  // data never carries bits outside the mask
  `BCR_ASSERT_IMPLIES(a_word_in_mask, !empty, (target_word & ~write_mask) == '0, "data outside mask")
  // a word that is not the last one was filled up to its top bit
  `BCR_ASSERT_IMPLIES(a_nonlast_full, !empty && !last, write_mask[WORD_BITS-1], "short non-last word")
  // after reset nothing is waiting and the input is open
  `BCR_ASSERT_NEXT(a_reset_clear, rst, empty && !full, "state not cleared by reset")

endmodule

### tb/sv/bitmap_copy_realigner_tb.sv
// testbench for the bitmap copy realigner: directed copy jobs, then random jobs under idling
// and a long output hold-off; every word transaction is checked against an in-bench predictor
// depends on bcr_pkg and bitmap_copy_realigner
module bitmap_copy_realigner_tb;
  import bcr_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  // one expected target word write
  typedef struct {
    logic [WORD_BITS-1:0]   word;
    logic [WORD_BITS-1:0]   mask;
    logic [INDEX_WIDTH-1:0] idx;
    logic                   last_flag;
  } target_write_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic                   mode = MODE_START;
  logic [7:0]             source_byte = '0;
  logic [2:0]             source_bit_offset = '0;
  logic [31:0]            target_bit_offset = '0;
  logic [31:0]            bit_count = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [WORD_BITS-1:0]   target_word;
  logic [WORD_BITS-1:0]   write_mask;
  logic [INDEX_WIDTH-1:0] word_index;
  logic                   last;

  // words predicted but not yet popped, oldest first
  target_write_t expected_writes[$];

  // predictor copy of the packing state
  logic [WORD_BITS-1:0]   pk_word = '0;
  int                     fill_pos = 0;
  int                     word_start = 0;
  logic [31:0]            bits_left = '0;
  logic [INDEX_WIDTH-1:0] word_idx = '0;
  logic [2:0]             skip_first = '0;
  bit                     first_pending = 1'b0;

  int mismatches = 0;
  int cycle_count = 0;
  int live_items = 0;      // starts and bytes that a job actually consumes
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int hold_left = 0;       // cycles left in an output hold-off

  bitmap_copy_realigner uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .source_byte(source_byte),
    .source_bit_offset(source_bit_offset),
    .target_bit_offset(target_bit_offset),
    .bit_count(bit_count),
    .empty(empty),
    .pop(pop),
    .target_word(target_word),
    .write_mask(write_mask),
    .word_index(word_index),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // low n bits set, all ones from a full word upward
  function automatic logic [WORD_BITS-1:0] low_ones(int n);
    if (n >= WORD_BITS) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // source bytes a job of cnt bits consumes when skip bits of the first byte are dropped
  function automatic longint bytes_for(logic [2:0] skip, logic [31:0] cnt);
    return (longint'(cnt) + longint'(skip) + 7) / 8;
  endfunction

  // queue the current word, masked from the word start up to bit position hi
  task automatic queue_write(int hi, logic lst);
    target_write_t w;
    w.mask = low_ones(hi) & ~low_ones(word_start);
    w.word = pk_word & w.mask;
    w.idx = word_idx;
    w.last_flag = lst;
    expected_writes.push_back(w);
  endtask

  // advance the packing state by one accepted transaction and queue the words it closes
  task automatic pack_transaction(logic m, logic [7:0] b, logic [2:0] so, logic [31:0] to,
                                  logic [31:0] cnt);
    int skip;
    int take;
    int top_pos;
    int spill;
    logic [WORD_BITS-1:0] chunk;
    if (m == MODE_START) begin
      // a new job drops any unfinished word without writing it
      bits_left = cnt;
      word_start = int'(to[5:0]);
      fill_pos = word_start;
      word_idx = to[31:6];
      skip_first = so;
      first_pending = 1'b1;
      pk_word = '0;
      return;
    end
    // no job active or count used up: byte ignored
    if (bits_left == 0) return;
    skip = first_pending ? int'(skip_first) : 0;
    first_pending = 1'b0;
    take = 8 - skip;
    if (longint'(take) > longint'(bits_left)) take = int'(bits_left);
    chunk = (64'(b) >> skip) & low_ones(take);
    bits_left = bits_left - 32'(take);
    pk_word = pk_word | (chunk << fill_pos);
    top_pos = fill_pos + take;
    if (top_pos >= WORD_BITS) begin
      spill = top_pos - WORD_BITS;
      queue_write(WORD_BITS, bits_left == 0 && spill == 0);
      // bits that overflowed the full word start the next one
      pk_word = (spill != 0) ? (chunk >> (WORD_BITS - fill_pos)) : '0;
      word_idx = word_idx + INDEX_WIDTH'(1);
      word_start = 0;
      fill_pos = spill;
      if (bits_left == 0 && spill != 0) queue_write(spill, 1'b1);
    end else begin
      fill_pos = top_pos;
      if (bits_left == 0) queue_write(top_pos, 1'b1);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // monitor: predict on each accepted input transaction, check each popped word
  always @(posedge clk) begin
    target_write_t want;
    if (!rst) begin
      if (push && !full)
        pack_transaction(mode, source_byte, source_bit_offset, target_bit_offset, bit_count);
      if (pop && !empty) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("word with nothing expected", target_word, '0);
        end else begin
          want = expected_writes.pop_front();
          if (target_word !== want.word) report_mismatch("target_word", target_word, want.word);
          if (write_mask !== want.mask) report_mismatch("write_mask", write_mask, want.mask);
          if (word_index !== want.idx)
            report_mismatch("word_index", 64'(word_index), 64'(want.idx));
          if (last !== want.last_flag)
            report_mismatch("last", 64'(last), 64'(want.last_flag));
        end
      end
    end
  end

  // receiver: random stalls, plus a forced hold-off while hold_left runs down
  always @(posedge clk) begin
    pop <= !rst && hold_left == 0 && ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("bitmap_copy_realigner_tb NOT OK");
      $finish;
    end
  end

  // offer one transaction after random idle cycles and wait until it is taken;
  // fields unused by the mode carry random values
  task automatic send_item(logic m, logic [7:0] b, logic [2:0] so, logic [31:0] to,
                           logic [31:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    mode <= m;
    if (m == MODE_START) begin
      source_byte <= 8'($urandom);
      source_bit_offset <= so;
      target_bit_offset <= to;
      bit_count <= cnt;
    end else begin
      source_byte <= b;
      source_bit_offset <= 3'($urandom);
      target_bit_offset <= $urandom;
      bit_count <= $urandom;
    end
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // start a job and feed it n bytes; fill below zero means random bytes
  task automatic run_job(logic [2:0] so, logic [31:0] to, logic [31:0] cnt, int n, int fill);
    longint used;
    used = bytes_for(so, cnt);
    if (longint'(n) < used) used = n;
    if (cnt == 0) used = 0;
    live_items += 1 + int'(used);
    send_item(MODE_START, '0, so, to, cnt);
    repeat (n) send_item(MODE_BYTE, (fill < 0) ? 8'($urandom) : 8'(fill), '0, '0, '0);
  endtask

  task automatic test_special_cases();
    send_idle_pct = 0;
    pop_stall_pct <= 0;
    // byte with no job since reset
    send_item(MODE_BYTE, 8'hFF, '0, '0, '0);
    // zero count: complete at once, following byte ignored
    run_job(3'd0, 32'd0, 32'd0, 1, 8'hFF);
    // one bit at the top of a word, next bit opens the following word
    run_job(3'd7, 32'd63, 32'd2, 2, 8'hFF);
    // one byte closes a full word and the final partial one; index wraps to zero
    run_job(3'd0, 32'hFFFF_FFFC, 32'd8, 1, 8'hA5);
    // bytes beyond the count are ignored
    run_job(3'd3, 32'd5, 32'd4, 2, 8'h00);
    // huge count abandoned by the next start
    run_job(3'd1, 32'h8000_0040, 32'hFFFF_FFFF, 2, 8'h5A);
    // exactly one aligned word: last lands on the full word
    run_job(3'd0, 32'd320, 32'd64, 8, -1);
  endtask

  // mostly well-formed jobs with random content, some empty, abandoned or stray bytes
  task automatic test_random_jobs(int target, int sidle, int pstall);
    int goal;
    int pick;
    int n;
    logic [2:0] so;
    logic [31:0] to;
    logic [31:0] cnt;
    send_idle_pct = sidle;
    pop_stall_pct <= pstall;
    goal = live_items + target;
    while (live_items < goal) begin
      pick = $urandom_range(99);
      so = 3'($urandom);
      to = ($urandom_range(9) == 0) ? (32'hFFFF_FFC0 | $urandom_range(63)) : $urandom;
      if (pick < 80) begin
        cnt = ($urandom_range(9) == 0) ? $urandom_range(101, 600) : $urandom_range(1, 100);
        n = int'(bytes_for(so, cnt));
        if ($urandom_range(9) == 0) n += $urandom_range(1, 3);
        run_job(so, to, cnt, n, -1);
      end else if (pick < 88) begin
        run_job(so, to, 32'd0, $urandom_range(0, 2), -1);
      end else if (pick < 95) begin
        // long or random count, cut short by the next start
        cnt = $urandom;
        run_job(so, to, cnt, $urandom_range(0, 24), -1);
      end else begin
        repeat ($urandom_range(1, 3)) send_item(MODE_BYTE, 8'($urandom), '0, '0, '0);
      end
    end
  endtask

  // output held off for a long stretch while input keeps coming, so full must assert
  task automatic test_backpressure();
    hold_left <= 600;
    test_random_jobs(100, 0, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_random_jobs(400, 0, 0);
    test_backpressure();
    test_random_jobs(400, 75, 0);
    test_random_jobs(350, 0, 75);
    test_random_jobs(300, 29, 29);
    push <= 1'b0;
    // drain, then give the pipeline time to show any stray word
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("bitmap_copy_realigner_tb OK");
    end else begin
      $display("bitmap_copy_realigner_tb NOT OK");
    end
    $finish;
  end

endmodule
